// File: src/tdpt_pkg.sv
// Package for the trial division prime test block.
// Holds the value width, stream widths, the controller state type and the divider result type.
// Depends on nothing.
package tdpt_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH);
    localparam int S_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = 8;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        value_t remainder;
    } div_result_t;

endpackage

// File: src/tdpt_divider.sv
// Bit-serial restoring divider for the trial division prime test block.
// Produces one quotient bit per cycle; depends on tdpt_pkg.
module tdpt_divider
    import tdpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  value_t      dividend,
    input  value_t      divisor,
    output div_result_t result
);

    value_t                 dvd_reg, dvd_next;
    value_t                 dsr_reg, dsr_next;
    value_t                 rem_reg, rem_next;
    value_t                 quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = COUNT_WIDTH'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            if (diff[VALUE_WIDTH])
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// File: src/trial_division_prime_test.sv
// Top level of the trial division prime test block.
// Runs trial divisors through tdpt_divider; depends on tdpt_pkg and tdpt_divider.
//
// The slave channel takes one candidate per beat in s_tdata; the master channel
// returns one beat per candidate whose m_tdata bit 0 is 1 for a prime.
// Candidates 0 and 1 are answered without division, and their result beat
// passes through ST_FINISH to the output register. Any larger candidate
// is divided by d = 2, 3, 4, ... until d exceeds the quotient (prime) or a
// remainder is zero (composite). Each trial is one pass of the bit-serial
// divider; the result beat then passes through ST_FINISH to the output
// register, and the next candidate can be taken once the block is back in
// ST_IDLE. A prime near 2^31 takes about 46,340 trials.
// One candidate is worked on at a time; s_tready is high only while the block
// is idle. The result beat sits in an output register, so a new candidate is
// accepted while an earlier result waits for m_tready. If the receiver still
// stalls when the next result is ready, the block holds that result and does
// not accept further beats. Reset clears the controller and the output valid
// flag; no beat is lost or repeated across a stall.
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,  // candidate, zero padding
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata   // is_prime, zero padding
);

    state_t      state_reg, state_next;
    value_t      cand_reg, cand_next;
    value_t      div_reg, div_next;
    logic        res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_prime_reg, out_prime_next;
    logic        div_start;
    value_t      dividend;
    div_result_t div_res;

    tdpt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (div_next),
        .result   (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        div_next       = div_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        div_start      = 1'b0;
        dividend       = cand_reg;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cand_next = s_tdata[VALUE_WIDTH-1:0];
                    dividend  = s_tdata[VALUE_WIDTH-1:0];
                    div_next  = VALUE_WIDTH'(2);
                    if (s_tdata[VALUE_WIDTH-1:1] == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    if (div_reg > div_res.quotient)
                    begin
                        res_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (div_res.remainder == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_next  = div_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        div_reg       <= div_next;
        res_reg       <= res_next;
        out_prime_reg <= out_prime_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_WIDTH-1){1'b0}}, out_prime_reg};

endmodule
